>>> sv/grvp_pkg.sv
// grvp_pkg: types and constants shared by the grade request parser modules.
// Holds the result beat type, the source and phase codes and the message codes.
// No dependencies.
package grvp_pkg;

	localparam logic [7:0] HDR_LEGACY    = 8'h3F;
	localparam logic [7:0] HDR_NEW       = 8'h04;
	localparam logic [7:0] TYPE_GRADE    = 8'h22;
	localparam logic [7:0] TAG_NEW_GRADE = 8'h10;
	localparam logic [7:0] TAG_LEG_GRADE = 8'h28;
	localparam logic [7:0] HUB_KIND_8    = 8'h02;
	localparam logic [7:0] HUB_KIND_16   = 8'h03;

	localparam logic [62:0] POS_LIMIT = 63'd21474836;
	localparam logic [62:0] NEG_LIMIT = 63'd21474835;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	typedef enum logic [2:0] {
		SRC_HUB8    = 3'd0,
		SRC_HUB16   = 3'd1,
		SRC_HUBZERO = 3'd2,
		SRC_LEGACY  = 3'd3,
		SRC_NEW     = 3'd4
	} grade_src_t;

	typedef enum logic [1:0] {
		PH_TAG   = 2'd0,
		PH_VALUE = 2'd1,
		PH_DONE  = 2'd2
	} parse_phase_t;

	typedef struct packed {
		logic signed [31:0] grade;
		grade_src_t         src;
		logic               last;
	} result_t;

endpackage

>>> sv/grvp_zigzag.sv
// grvp_zigzag: zigzag decode of a 64-bit varint, scaled by 100 and saturated.
// Pure combinational logic; depends on grvp_pkg.
module grvp_zigzag import grvp_pkg::*; (
	input  logic [63:0]        value,
	output logic signed [31:0] grade
);

	logic [62:0] mag;
	logic [31:0] mag_ext;
	logic [31:0] mag_inc;
	logic [31:0] pos_prod;
	logic [31:0] neg_prod;

	assign mag      = value[63:1];
	assign mag_ext  = {7'd0, mag[24:0]};
	assign mag_inc  = mag_ext + 32'd1;
	// times 100 as 64 + 32 + 4
	assign pos_prod = (mag_ext << 6) + (mag_ext << 5) + (mag_ext << 2);
	assign neg_prod = (mag_inc << 6) + (mag_inc << 5) + (mag_inc << 2);

	always_comb begin
		if (!value[0]) begin
			if (mag > POS_LIMIT) begin
				grade = 32'sh7FFF_FFFF;
			end else begin
				grade = signed'(pos_prod);
			end
		end else begin
			if (mag > NEG_LIMIT) begin
				grade = signed'(32'h8000_0000);
			end else begin
				grade = signed'(32'd0 - neg_prod);
			end
		end
	end

endmodule

>>> sv/grvp_result_fifo.sv
// grvp_result_fifo: small result queue taking up to two beats per cycle, one out.
// Depends on grvp_pkg for the result type and depth.
module grvp_result_fifo import grvp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_n,
	input  result_t    push_data [2],
	output logic       room,
	output logic       out_valid,
	input  logic       out_ready,
	output result_t    out_data
);

	result_t                 mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [FIFO_CNT_W-1:0]   count_q;
	logic                    pop;

	assign out_valid = count_q != '0;
	assign out_data  = mem[rd_ptr_q];
	assign pop       = out_valid & out_ready;
	// room for a two-beat push
	assign room      = count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem[wr_ptr_q] <= push_data[0];
		end
		if (push_n == 2'd2) begin
			mem[wr_ptr_q + FIFO_PTR_W'(1)] <= push_data[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			count_q <= count_q + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
		end
	end

endmodule

>>> sv/grade_request_varint_parser_unit.sv
// grade_request_varint_parser_unit: byte-wide request parser giving road grades.
// Each input beat passes through an input register, then the result queue, before its results come out.
// Throughput: one input beat per cycle; a byte that yields two results pushes both
// into the 4-entry result queue at once, and the queue stalls input when nearly full.
// Reset: async active-low; clears parse state, queue, and sets the format bit fmt_q to 1.
// Depends on grvp_pkg, grvp_zigzag, grvp_result_fifo.
module grade_request_varint_parser_unit import grvp_pkg::*; #(
	parameter int VARINT_MAX_BYTES = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic               cfg_write_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] grade_e4,
	output logic [2:0]         grade_source,
	output logic               last_in_run
);

	localparam int CNT_W = $clog2(VARINT_MAX_BYTES + 1);

	logic               fmt_q;
	logic               valid_s1;
	logic [7:0]         data_s1;
	logic               last_s1;
	logic [2:0]         pos_q;
	logic [7:0]         header_q;
	logic [7:0]         type_q;
	logic [7:0]         hub0_q, hub1_q, hub2_q, hub3_q;
	parse_phase_t       phase_q, phase_d;
	logic [7:0]         tag_q, tag_d;
	logic [63:0]        varint_q, varint_d, varint_acc;
	logic [CNT_W-1:0]   cnt_q, cnt_d, cnt_inc;
	logic signed [31:0] pend_q;
	logic               pend_valid_q;

	logic               room;
	logic               fire;
	logic               newfmt;
	logic               tag_en;
	logic               have_new;
	logic signed [31:0] zig_grade;
	grade_src_t         new_src;
	logic [5:0]         shamt;
	logic [7:0]         hub2_eff, hub3_eff;
	logic [31:0]        hub8_prod, hub16_prod;
	logic               hub_hit;
	logic [1:0]         n;
	result_t            res [2];
	result_t            fifo_out;

	assign fire     = valid_s1 & room;
	assign in_ready = !valid_s1 | fire;
	assign newfmt   = fmt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= 1'b1;
		end else if (cfg_write_en) begin
			fmt_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid & in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid & in_ready) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// tag/value parsing
	assign tag_en = (pos_q != 3'd0) &&
		((newfmt && header_q == HDR_NEW) || (!newfmt && header_q == HDR_LEGACY));
	assign shamt      = 6'(32'(cnt_q) * 32'd7);
	assign varint_acc = varint_q | (64'(data_s1[6:0]) << shamt);
	assign cnt_inc    = cnt_q + CNT_W'(1);

	always_comb begin
		phase_d  = phase_q;
		tag_d    = tag_q;
		varint_d = varint_q;
		cnt_d    = cnt_q;
		have_new = 1'b0;
		new_src  = SRC_NEW;
		if (tag_en) begin
			case (phase_q)
				PH_TAG: begin
					tag_d    = data_s1;
					varint_d = '0;
					cnt_d    = '0;
					phase_d  = PH_VALUE;
				end
				PH_VALUE: begin
					varint_d = varint_acc;
					cnt_d    = cnt_inc;
					if (!data_s1[7]) begin
						phase_d = PH_TAG;
						if (newfmt && type_q == TYPE_GRADE && tag_q == TAG_NEW_GRADE) begin
							have_new = 1'b1;
							new_src  = SRC_NEW;
						end else if (!newfmt && tag_q == TAG_LEG_GRADE) begin
							have_new = 1'b1;
							new_src  = SRC_LEGACY;
						end
					end else if (cnt_inc >= CNT_W'(VARINT_MAX_BYTES)) begin
						phase_d = PH_DONE;
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	grvp_zigzag u_zigzag (
		.value (varint_acc),
		.grade (zig_grade)
	);

	// hub bytes written this beat are seen right away
	assign hub2_eff   = (pos_q == 3'd4) ? data_s1 : hub2_q;
	assign hub3_eff   = (pos_q == 3'd5) ? data_s1 : hub3_q;
	assign hub8_prod  = 32'(hub2_eff) * 32'd250;
	assign hub16_prod = 32'({hub3_eff, hub2_eff}) * 32'd25;
	assign hub_hit    = last_s1 && !newfmt && pos_q >= 3'd4 && header_q == HDR_NEW &&
		type_q == TYPE_GRADE && hub1_q == TAG_NEW_GRADE;

	always_comb begin
		n      = 2'd0;
		res[0] = '{grade: '0, src: SRC_HUBZERO, last: 1'b0};
		res[1] = '{grade: '0, src: SRC_HUBZERO, last: 1'b1};
		if (pos_q >= 3'd4) begin
			if (pend_valid_q) begin
				res[0].grade = pend_q;
				res[0].src   = SRC_LEGACY;
				n            = 2'd1;
			end
			if (have_new) begin
				res[n[0]].grade = zig_grade;
				res[n[0]].src   = new_src;
				n               = n + 2'd1;
			end
		end else if (have_new && newfmt) begin
			res[0].grade = zig_grade;
			res[0].src   = new_src;
			n            = 2'd1;
		end
		if (hub_hit && n != 2'd2) begin
			if (hub0_q == HUB_KIND_8) begin
				res[n[0]].grade = signed'(hub8_prod);
				res[n[0]].src   = SRC_HUB8;
			end else if (hub0_q == HUB_KIND_16 && pos_q >= 3'd5) begin
				res[n[0]].grade = signed'(hub16_prod);
				res[n[0]].src   = SRC_HUB16;
			end else begin
				res[n[0]].grade = '0;
				res[n[0]].src   = SRC_HUBZERO;
			end
			n = n + 2'd1;
		end
		res[0].last = n == 2'd1;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			case (pos_q)
				3'd0: header_q <= data_s1;
				3'd1: type_q   <= data_s1;
				3'd2: hub0_q   <= data_s1;
				3'd3: hub1_q   <= data_s1;
				3'd4: hub2_q   <= data_s1;
				3'd5: hub3_q   <= data_s1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			phase_q      <= PH_TAG;
			tag_q        <= '0;
			varint_q     <= '0;
			cnt_q        <= '0;
			pend_q       <= '0;
			pend_valid_q <= 1'b0;
		end else if (fire) begin
			if (last_s1) begin
				pos_q        <= '0;
				phase_q      <= PH_TAG;
				tag_q        <= '0;
				varint_q     <= '0;
				cnt_q        <= '0;
				pend_q       <= '0;
				pend_valid_q <= 1'b0;
			end else begin
				if (pos_q != 3'd7) begin
					pos_q <= pos_q + 3'd1;
				end
				phase_q  <= phase_d;
				tag_q    <= tag_d;
				varint_q <= varint_d;
				cnt_q    <= cnt_d;
				// legacy grade before the fifth byte waits
				if (pos_q >= 3'd4) begin
					pend_valid_q <= 1'b0;
				end else if (have_new && !newfmt) begin
					pend_q       <= zig_grade;
					pend_valid_q <= 1'b1;
				end
			end
		end
	end

	grvp_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (fire ? n : 2'd0),
		.push_data (res),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (fifo_out)
	);

	assign grade_e4     = fifo_out.grade;
	assign grade_source = fifo_out.src;
	assign last_in_run  = fifo_out.last;

endmodule
